[rtl/bsc_pkg.sv]
// Shared types and constants of the clipped 3x3 box smoothing filter.
`default_nettype none
package bsc_pkg;
	localparam int MAX_WIDTH_DEF   = 32;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int WIDTH_BITS      = 6;
	localparam int HEIGHT_BITS     = 11;
	localparam int CFG_BITS        = 11;
	localparam int ROW_BITS        = 10;
	localparam int MAX_HEIGHT      = 1024;
	localparam int DIV_BITS        = 4;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		JOB_PTR,
		JOB_PREV,
		JOB_CUR
	} job_t;

	typedef struct packed {
		logic write;
		logic start;
		job_t job;
		logic adv_ptr;
		logic adv_in;
	} cmd_t;

	typedef struct packed {
		logic ptr_ok;
		logic lr_a_ok;
		logic lr_b_ok;
		logic done;
	} sts_t;
endpackage
`default_nettype wire

[rtl/bsc_div.sv]
// Divider of window sums by the window pixel count, using shifts and reciprocal multiplication.
`default_nettype none
module bsc_div #(
	parameter int SUM_BITS = 20
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [SUM_BITS-1:0]            dividend,
	input  wire logic [bsc_pkg::DIV_BITS-1:0]   divisor,
	output logic                                done,
	output logic [SUM_BITS-1:0]                 quotient
);
	import bsc_pkg::*;

	localparam int LO_BITS = SUM_BITS / 2;
	localparam int HI_BITS = SUM_BITS - LO_BITS;
	localparam int SHIFT   = SUM_BITS + 2;
	localparam int M_BITS  = SUM_BITS + 1;
	localparam int PL_BITS = LO_BITS + M_BITS;
	localparam int PH_BITS = HI_BITS + M_BITS;
	localparam int P_BITS  = SUM_BITS + M_BITS;
	localparam logic [M_BITS-1:0] RECIP3 = M_BITS'(((64'd1 << SHIFT) + 64'd2) / 64'd3);

	logic [SUM_BITS-1:0] val_q;
	logic [PL_BITS-1:0]  plo_q;
	logic [1:0]          pass_q;
	logic                half_q;
	logic                busy_q;
	logic                done_q;
	logic [PL_BITS-1:0]  plo;
	logic [PH_BITS-1:0]  phi;
	logic [P_BITS-1:0]   full;
	logic [SUM_BITS-1:0] shifted;
	logic [1:0]          passes;

	// Division by three is a multiplication by the rounded-up reciprocal, split into
	// the low and the high half of the operand, one after the other. Nine is three twice.
	assign plo  = PL_BITS'(val_q[LO_BITS-1:0]) * PL_BITS'(RECIP3);
	assign phi  = PH_BITS'(val_q[SUM_BITS-1:LO_BITS]) * PH_BITS'(RECIP3);
	assign full = {phi, {LO_BITS{1'b0}}} + P_BITS'(plo_q);

	always_comb begin
		unique case (divisor)
			DIV_BITS'(2), DIV_BITS'(6): shifted = dividend >> 1;
			DIV_BITS'(4):               shifted = dividend >> 2;
			default:                    shifted = dividend;
		endcase
		unique case (divisor)
			DIV_BITS'(3), DIV_BITS'(6): passes = 2'd1;
			DIV_BITS'(9):               passes = 2'd2;
			default:                    passes = 2'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			half_q <= 1'b0;
			pass_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				half_q <= 1'b0;
				pass_q <= passes;
			end else if (busy_q) begin
				if (pass_q == 2'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else if (!half_q) begin
					half_q <= 1'b1;
				end else begin
					half_q <= 1'b0;
					pass_q <= pass_q - 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= shifted;
		end else if (busy_q && (pass_q != 2'd0)) begin
			if (!half_q) begin
				plo_q <= plo;
			end else begin
				val_q <= SUM_BITS'(full[P_BITS-1:SHIFT]);
			end
		end
	end

	assign done     = done_q;
	assign quotient = val_q;
endmodule
`default_nettype wire

[rtl/bsc_dpath.sv]
// Datapath: configuration, position counters, three-row line store, window sum and divider.
`default_nettype none
module bsc_dpath #(
	parameter int MAX_WIDTH   = bsc_pkg::MAX_WIDTH_DEF,
	parameter int SAMPLE_BITS = bsc_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          wr_en,
	input  wire logic                          wr_index,
	input  wire logic [bsc_pkg::CFG_BITS-1:0]  wr_data,
	input  wire logic [SAMPLE_BITS-1:0]        sample,
	input  wire bsc_pkg::cmd_t                 cmd,
	output bsc_pkg::sts_t                      sts,
	output logic [SAMPLE_BITS-1:0]             smoothed,
	output logic                               frame_end
);
	import bsc_pkg::*;

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int DEPTH = 3 * MAX_WIDTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int SW    = SAMPLE_BITS + 4;

	logic [WIDTH_BITS-1:0]  width_q;
	logic [HEIGHT_BITS-1:0] height_q;
	logic [CW-1:0]          wm1;
	logic [ROW_BITS-1:0]    hm1;

	logic [CW-1:0]       in_col_q, out_col_q;
	logic [ROW_BITS-1:0] in_row_q, out_row_q;
	logic [1:0]          in_slot_q, out_slot_q;

	logic [SAMPLE_BITS-1:0] store [DEPTH];
	logic [SAMPLE_BITS-1:0] rd_data_s1;
	logic [AW-1:0]          rd_addr, wr_addr;

	logic [CW-1:0]       cx_q, jx;
	logic [ROW_BITS-1:0] cy_q, jy;
	logic [1:0]          cs_q, js;
	logic [DIV_BITS-1:0] n_q;
	logic                fe_q;
	logic [1:0]          r_q, c_q;
	logic                rd_busy_q, acc_en_s1, tail_q, div_go_q;
	logic [SW-1:0]       acc_q;
	logic [SAMPLE_BITS-1:0] res_q;
	logic                div_done;
	logic [SW-1:0]       quo;

	logic [1:0]          nxc, nyc;
	logic                pres, rp, cp;
	logic [1:0]          rslot;
	logic [CW-1:0]       xx;
	logic [ROW_BITS:0]   ny;
	logic [CW-1:0]       nx;

	function automatic logic [1:0] slot_next(input logic [1:0] s);
		return (s == 2'd2) ? 2'd0 : s + 2'd1;
	endfunction

	function automatic logic [1:0] slot_prev(input logic [1:0] s);
		return (s == 2'd0) ? 2'd2 : s - 2'd1;
	endfunction

	function automatic logic [AW-1:0] slot_base(input logic [1:0] s);
		logic [AW-1:0] b;
		unique case (s)
			2'd0:    b = '0;
			2'd1:    b = AW'(MAX_WIDTH);
			default: b = AW'(2 * MAX_WIDTH);
		endcase
		return b;
	endfunction

	always_comb begin
		int weff;
		int heff;
		weff = (width_q == '0) ? 1 : int'(width_q);
		if (weff > MAX_WIDTH) weff = MAX_WIDTH;
		heff = (height_q == '0) ? 1 : int'(height_q);
		if (heff > MAX_HEIGHT) heff = MAX_HEIGHT;
		wm1 = CW'(weff - 1);
		hm1 = ROW_BITS'(heff - 1);
	end

	assign ny = {1'b0, out_row_q} + 1'b1;
	assign nx = (out_col_q < wm1) ? out_col_q + 1'b1 : wm1;

	always_comb begin
		sts.ptr_ok  = (out_row_q < hm1) &&
			((ny < {1'b0, in_row_q}) || ((ny == {1'b0, in_row_q}) && (nx <= in_col_q)));
		sts.lr_a_ok = (in_row_q == hm1) && (in_col_q != '0);
		sts.lr_b_ok = (in_row_q == hm1) && (in_col_q == wm1);
		sts.done    = div_done;
	end

	always_comb begin
		unique case (cmd.job)
			JOB_PTR: begin
				jx = out_col_q;
				jy = out_row_q;
				js = out_slot_q;
			end
			JOB_PREV: begin
				jx = in_col_q - 1'b1;
				jy = in_row_q;
				js = in_slot_q;
			end
			default: begin
				jx = in_col_q;
				jy = in_row_q;
				js = in_slot_q;
			end
		endcase
		nxc = 2'd1 + {1'b0, jx != '0} + {1'b0, jx < wm1};
		nyc = 2'd1 + {1'b0, jy != '0} + {1'b0, jy < hm1};
	end

	always_comb begin
		rp = (r_q == 2'd0) ? (cy_q != '0) : (r_q == 2'd2) ? (cy_q < hm1) : 1'b1;
		cp = (c_q == 2'd0) ? (cx_q != '0) : (c_q == 2'd2) ? (cx_q < wm1) : 1'b1;
		pres  = rp && cp;
		rslot = (r_q == 2'd0) ? slot_prev(cs_q) : (r_q == 2'd2) ? slot_next(cs_q) : cs_q;
		xx    = cx_q + CW'(c_q) - CW'(1);
		rd_addr = pres ? slot_base(rslot) + AW'(xx) : '0;
		wr_addr = slot_base(in_slot_q) + AW'(in_col_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= WIDTH_BITS'(5);
			height_q   <= HEIGHT_BITS'(5);
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_slot_q  <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_slot_q <= '0;
		end else if (wr_en) begin
			if (wr_index == REG_WIDTH) begin
				width_q <= wr_data[WIDTH_BITS-1:0];
			end else begin
				height_q <= wr_data[HEIGHT_BITS-1:0];
			end
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_slot_q  <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_slot_q <= '0;
		end else if (cmd.adv_ptr) begin
			if (out_col_q == wm1) begin
				out_col_q  <= '0;
				out_row_q  <= out_row_q + 1'b1;
				out_slot_q <= slot_next(out_slot_q);
			end else begin
				out_col_q <= out_col_q + 1'b1;
			end
		end else if (cmd.adv_in) begin
			if (in_col_q == wm1) begin
				in_col_q <= '0;
				if (in_row_q == hm1) begin
					in_row_q   <= '0;
					in_slot_q  <= '0;
					out_col_q  <= '0;
					out_row_q  <= '0;
					out_slot_q <= '0;
				end else begin
					in_row_q  <= in_row_q + 1'b1;
					in_slot_q <= slot_next(in_slot_q);
				end
			end else begin
				in_col_q <= in_col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write) begin
			store[wr_addr] <= sample;
		end
		rd_data_s1 <= store[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_busy_q <= 1'b0;
			acc_en_s1 <= 1'b0;
			tail_q    <= 1'b0;
			div_go_q  <= 1'b0;
			r_q       <= '0;
			c_q       <= '0;
		end else begin
			acc_en_s1 <= rd_busy_q && pres;
			tail_q    <= 1'b0;
			div_go_q  <= tail_q;
			if (cmd.start) begin
				rd_busy_q <= 1'b1;
				r_q       <= '0;
				c_q       <= '0;
			end else if (rd_busy_q) begin
				if (c_q == 2'd2) begin
					c_q <= '0;
					r_q <= r_q + 1'b1;
					if (r_q == 2'd2) begin
						rd_busy_q <= 1'b0;
						tail_q    <= 1'b1;
					end
				end else begin
					c_q <= c_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			cx_q  <= jx;
			cy_q  <= jy;
			cs_q  <= js;
			n_q   <= DIV_BITS'(nxc * nyc);
			fe_q  <= (jx == wm1) && (jy == hm1);
			acc_q <= '0;
		end else if (acc_en_s1) begin
			acc_q <= acc_q + SW'(rd_data_s1);
		end
		if (div_done) begin
			res_q <= quo[SAMPLE_BITS-1:0];
		end
	end

	bsc_div #(
		.SUM_BITS (SW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go_q),
		.dividend (acc_q),
		.divisor  (n_q),
		.done     (div_done),
		.quotient (quo)
	);

	assign smoothed  = res_q;
	assign frame_end = fe_q;
endmodule
`default_nettype wire

[rtl/bsc_ctrl.sv]
// Controller: sequences the results caused by each input transaction.
`default_nettype none
module bsc_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  wire logic           out_stall,
	output logic                run_last,
	input  wire bsc_pkg::sts_t  sts,
	output bsc_pkg::cmd_t       cmd
);
	import bsc_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_FIND,
		S_CALC,
		S_OUT
	} state_t;

	typedef enum logic [1:0] {
		PH_PTR,
		PH_LRA,
		PH_LRB,
		PH_DONE
	} phase_t;

	state_t state_q;
	phase_t phase_q;
	job_t   job_q;
	job_t   job;
	logic [1:0] k_q;
	logic   pend_q, last_q, found;

	always_comb begin
		found = 1'b0;
		job   = JOB_PTR;
		unique case (phase_q)
			PH_PTR: begin
				found = (k_q != 2'd3) && sts.ptr_ok;
				job   = JOB_PTR;
			end
			PH_LRA: begin
				found = sts.lr_a_ok;
				job   = JOB_PREV;
			end
			PH_LRB: begin
				found = sts.lr_b_ok;
				job   = JOB_CUR;
			end
			default: begin
				found = 1'b0;
				job   = JOB_CUR;
			end
		endcase
	end

	always_comb begin
		cmd.write   = (state_q == S_IDLE) && in_valid;
		cmd.start   = (state_q == S_FIND) && found && !pend_q;
		cmd.job     = job;
		cmd.adv_ptr = (state_q == S_CALC) && sts.done && (job_q == JOB_PTR);
		cmd.adv_in  = (state_q == S_FIND) && (phase_q == PH_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_PTR;
			job_q   <= JOB_PTR;
			k_q     <= '0;
			pend_q  <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						phase_q <= PH_PTR;
						k_q     <= '0;
						state_q <= S_FIND;
					end
				end
				S_FIND: begin
					if (phase_q == PH_DONE) begin
						last_q  <= 1'b1;
						state_q <= pend_q ? S_OUT : S_IDLE;
					end else if (found) begin
						if (pend_q) begin
							last_q  <= 1'b0;
							state_q <= S_OUT;
						end else begin
							job_q   <= job;
							state_q <= S_CALC;
						end
					end else begin
						unique case (phase_q)
							PH_PTR:  phase_q <= PH_LRA;
							PH_LRA:  phase_q <= PH_LRB;
							default: phase_q <= PH_DONE;
						endcase
					end
				end
				S_CALC: begin
					if (sts.done) begin
						pend_q  <= 1'b1;
						state_q <= S_FIND;
						unique case (job_q)
							JOB_PTR:  k_q <= k_q + 1'b1;
							JOB_PREV: phase_q <= PH_LRB;
							default:  phase_q <= PH_DONE;
						endcase
					end
				end
				default: begin
					if (!out_stall) begin
						pend_q  <= 1'b0;
						state_q <= last_q ? S_IDLE : S_FIND;
					end
				end
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign run_last  = last_q;
endmodule
`default_nettype wire

[rtl/box_smooth_3x3_clipped.sv]
// Top level of the clipped 3x3 box smoothing filter.
`default_nettype none
// Streaming 3x3 mean filter over a frame of image_width by image_height samples in
// raster order; each output is the truncated mean of its window clipped to the frame.
// One input transaction is taken at a time. A transaction that causes no result
// occupies the accept cycle and the control steps that look for results. Each result
// it causes adds a start, nine line store reads, the read and accumulate pipeline,
// a divider load and the divide passes, then control steps and the output transaction;
// the single read port of the line store sets most of the time a result takes.
// A configuration write restarts the frame; write only while the block is idle.
module box_smooth_3x3_clipped #(
	parameter int MAX_WIDTH   = bsc_pkg::MAX_WIDTH_DEF,
	parameter int SAMPLE_BITS = bsc_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          wr_en,
	input  wire logic                          wr_index,
	input  wire logic [bsc_pkg::CFG_BITS-1:0]  wr_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [SAMPLE_BITS-1:0]        sample,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [SAMPLE_BITS-1:0]             smoothed,
	output logic                               frame_end,
	output logic                               run_last
);
	import bsc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	bsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.run_last  (run_last),
		.sts       (sts),
		.cmd       (cmd)
	);

	bsc_dpath #(
		.MAX_WIDTH   (MAX_WIDTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.sample    (sample),
		.cmd       (cmd),
		.sts       (sts),
		.smoothed  (smoothed),
		.frame_end (frame_end)
	);
endmodule
`default_nettype wire
